[sv/bis_pkg.sv]
// Package with types and constants of the bicubic image sampler.
package bis_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int FRAC_BITS   = 8;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int SIZE_BITS   = 9;
    localparam int COORD_BITS  = 20;
    localparam int INT_BITS    = COORD_BITS - FRAC_BITS;
    localparam int WEIGHT_BITS = 30;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    localparam logic [1:0] MODE_CLAMP    = 2'd0;
    localparam logic [1:0] MODE_PERIODIC = 2'd1;
    localparam logic [1:0] MODE_MIRROR   = 2'd2;
    localparam logic [1:0] MODE_CUT      = 2'd3;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [15:0]        load_address;
        logic signed [15:0] pixel_value;
        logic signed [19:0] x_pos;
        logic signed [19:0] y_pos;
    } bis_in_t;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic               out_of_bounds;
        logic               saturated;
    } bis_out_t;

    // Kernel weights in Q2.30, exact for eight fraction bits: each integer
    // weight over 2*S^3 is scaled by 2^(30-25).
    function automatic logic signed [31:0] kern_weight(input logic [FRAC_BITS-1:0] f,
                                                       input logic [1:0] k);
        logic signed [40:0] fs, s, f2, f3, n;
        begin
            fs = 41'($unsigned(f));
            s  = 41'sd1 <<< FRAC_BITS;
            f2 = fs * fs;
            f3 = f2 * fs;
            case (k)
                2'd0:    n = -f3 + 2 * f2 * s - fs * s * s;
                2'd1:    n = 3 * f3 - 5 * f2 * s + 2 * s * s * s;
                2'd2:    n = -3 * f3 + 4 * f2 * s + fs * s * s;
                default: n = f3 - f2 * s;
            endcase
            kern_weight = 32'(n <<< (WEIGHT_BITS - 3 * FRAC_BITS - 1));
        end
    endfunction

endpackage

[sv/bicubic_image_sampler.sv]
// Top level of the bicubic image sampler: image memory, tap sequencer and MAC.
//
//  channel  direction  ports                        payload
//  s_       in         s_valid, s_ready, s_data     load or sample request
//  m_       out        m_valid, m_ready, m_data     sample result
//  cfg      in         cfg_we, cfg_index, cfg_data  size and boundary mode
//
// Loads can follow back to back. A sample passes through a setup state, a
// remap of the taps (a 12-step compare and subtract finds the first tap
// modulo the period, then one tap per cycle), 16 read and MAC pairs with
// four column passes, a final rounding and the output state. A cutting-mode
// miss goes from setup straight to the output state. The result waits
// in an output register while new requests are taken; a later sample holds
// in its output cycle until that register is free. Reset is synchronous and
// active low; the image memory is not cleared.
module bicubic_image_sampler (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bis_pkg::bis_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bis_pkg::bis_out_t           m_data,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [bis_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import bis_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_COL   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;
    localparam logic [2:0] ST_REMAP = 3'd7;

    logic [SIZE_BITS-1:0] width_reg, height_reg;
    logic [1:0]           mode_reg;
    logic [2:0]           state_reg, state_next;
    bis_in_t              req_reg;
    logic [3:0]           tap_reg;
    logic [8:0]           cx_reg [4];
    logic [8:0]           cy_reg [4];
    logic signed [31:0]   wx_reg [4];
    logic signed [31:0]   wy_reg [4];
    logic signed [63:0]   acc_reg;
    logic signed [63:0]   xacc_reg;
    logic signed [15:0]   mem_rd_reg;
    logic signed [15:0]   store [STORE_DEPTH];
    bis_out_t             res_reg;
    bis_out_t             out_reg;
    logic                 out_valid_reg;
    logic [11:0]          ax_reg, ay_reg;
    logic                 negx_reg, negy_reg;
    logic [9:0]           nx_reg, ny_reg;
    logic [9:0]           remx_reg, remy_reg;
    logic [3:0]           div_cnt_reg;

    logic [8:0] w_eff, h_eff;
    logic signed [INT_BITS-1:0] ix, iy;
    logic signed [INT_BITS+1:0] tx [4];
    logic signed [INT_BITS+1:0] ty [4];
    logic signed [INT_BITS+1:0] tx0_mag, ty0_mag;
    logic [9:0] nx_mod, ny_mod;
    logic [9:0] xs, ys, xs_red, ys_red;
    logic [9:0] xr, yr, xr_inc, yr_inc;
    logic [8:0] map_x, map_y;
    logic       cut_miss;
    logic       out_load;
    logic signed [63:0] rnd_acc, rnd_x;
    logic signed [33:0] col_val, fin_val;
    logic [ADDR_BITS-1:0] rd_addr;
    logic signed [63:0] mac_prod;
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;

    assign w_eff = (width_reg < 9'd2) ? 9'd2 :
                   (width_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg < 9'd2) ? 9'd2 :
                   (height_reg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_reg;

    // Arithmetic shift gives floor for both signs.
    assign ix = req_reg.x_pos[COORD_BITS-1:FRAC_BITS];
    assign iy = req_reg.y_pos[COORD_BITS-1:FRAC_BITS];

    // Maps one tap into 0..n-1. The residue r is the tap modulo the period:
    // n when periodic, 2(n-1) when mirrored, where the image folds back as a
    // triangle wave. Clamping works straight from the tap.
    function automatic logic [8:0] fold_tap(input logic [9:0] r,
                                            input logic [9:0] nmod,
                                            input logic signed [INT_BITS+1:0] t,
                                            input logic [8:0] n,
                                            input logic [1:0] mode);
        logic [8:0] b;
        begin
            b = n - 9'd1;
            case (mode)
                MODE_PERIODIC: fold_tap = r[8:0];
                MODE_MIRROR:   fold_tap = (r <= {1'b0, b}) ? r[8:0] : 9'(nmod - r);
                default: begin
                    if (t < 0)
                        fold_tap = 9'd0;
                    else if (t >= $signed({5'd0, n}))
                        fold_tap = b;
                    else
                        fold_tap = t[8:0];
                end
            endcase
        end
    endfunction

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            tx[k] = (INT_BITS+2)'(ix) - 1 + (INT_BITS+2)'(k);
            ty[k] = (INT_BITS+2)'(iy) - 1 + (INT_BITS+2)'(k);
        end
    end

    assign cut_miss = (mode_reg == MODE_CUT) &&
                      (tx[0] < 0 || tx[3] >= $signed({1'b0, w_eff}) ||
                       ty[0] < 0 || ty[3] >= $signed({1'b0, h_eff}));

    assign tx0_mag = (tx[0] < 0) ? -tx[0] : tx[0];
    assign ty0_mag = (ty[0] < 0) ? -ty[0] : ty[0];
    assign nx_mod  = (mode_reg == MODE_MIRROR) ? {w_eff - 9'd1, 1'b0} : {1'b0, w_eff};
    assign ny_mod  = (mode_reg == MODE_MIRROR) ? {h_eff - 9'd1, 1'b0} : {1'b0, h_eff};

    // One restoring step of the remainder per cycle, most significant bit first.
    assign xs     = {remx_reg[8:0], ax_reg[11]};
    assign ys     = {remy_reg[8:0], ay_reg[11]};
    assign xs_red = (xs >= nx_reg) ? xs - nx_reg : xs;
    assign ys_red = (ys >= ny_reg) ? ys - ny_reg : ys;

    // A negative first tap turns its remainder into the positive residue once.
    assign xr = (div_cnt_reg == 4'd12 && negx_reg && remx_reg != 10'd0) ?
                nx_reg - remx_reg : remx_reg;
    assign yr = (div_cnt_reg == 4'd12 && negy_reg && remy_reg != 10'd0) ?
                ny_reg - remy_reg : remy_reg;
    assign xr_inc = (xr + 10'd1 == nx_reg) ? 10'd0 : xr + 10'd1;
    assign yr_inc = (yr + 10'd1 == ny_reg) ? 10'd0 : yr + 10'd1;
    assign map_x  = fold_tap(xr, nx_reg, tx[div_cnt_reg[1:0]], w_eff, mode_reg);
    assign map_y  = fold_tap(yr, ny_reg, ty[div_cnt_reg[1:0]], h_eff, mode_reg);

    // Tap order: tap_reg[3:2] is the column, tap_reg[1:0] the row.
    assign rd_addr = ADDR_BITS'(cy_reg[tap_reg[1:0]]) * ADDR_BITS'(w_eff) +
                     ADDR_BITS'(cx_reg[tap_reg[3:2]]);

    function automatic logic signed [63:0] rshift(input logic signed [63:0] v);
        logic signed [63:0] q;
        begin
            q = v + (64'sd1 <<< (WEIGHT_BITS - 1));
            rshift = q >>> WEIGHT_BITS;
        end
    endfunction

    assign rnd_acc = rshift(acc_reg);
    assign rnd_x   = rshift(xacc_reg);
    assign col_val = 34'(rnd_acc);
    assign fin_val = 34'(rnd_x);

    // The one shared multiplier: pixel times y weight, or column times x weight.
    always_comb begin
        if (state_reg == ST_COL) begin
            mul_a = col_val;
            mul_b = wx_reg[tap_reg[3:2]];
        end else begin
            mul_a = 34'(mem_rd_reg);
            mul_b = wy_reg[tap_reg[1:0]];
        end
    end
    assign mac_prod = 64'(mul_a * mul_b);

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_ready);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid && s_ready && s_data.op == OP_LOAD &&
            32'(s_data.load_address) < STORE_DEPTH) begin
            store[ADDR_BITS'(s_data.load_address)] <= s_data.pixel_value;
        end
        mem_rd_reg <= store[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid && s_ready && s_data.op == OP_SAMPLE) state_next = ST_SETUP;
            ST_SETUP: state_next = cut_miss ? ST_OUT : ST_REMAP;
            ST_REMAP: if (div_cnt_reg == 4'd15) state_next = ST_READ;
            ST_READ:  state_next = ST_MAC;
            ST_MAC:   state_next = (tap_reg[1:0] == 2'd3) ? ST_COL : ST_READ;
            ST_COL:   state_next = (tap_reg == 4'hF) ? ST_FIN : ST_READ;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= 9'(MAX_WIDTH);
            height_reg    <= 9'(MAX_HEIGHT);
            mode_reg      <= MODE_CLAMP;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tap_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_MODE:   mode_reg   <= cfg_data[1:0];
                    default:    ;
                endcase
            end
            state_reg <= state_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (state_reg == ST_SETUP) tap_reg <= '0;
            else if (state_reg == ST_MAC && tap_reg[1:0] != 2'd3) tap_reg <= tap_reg + 4'd1;
            else if (state_reg == ST_COL) tap_reg <= tap_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid && s_ready) req_reg <= s_data;
        if (out_load) out_reg <= res_reg;
        case (state_reg)
            ST_SETUP: begin
                for (int k = 0; k < 4; k++) begin
                    wx_reg[k] <= kern_weight(req_reg.x_pos[FRAC_BITS-1:0], 2'(k));
                    wy_reg[k] <= kern_weight(req_reg.y_pos[FRAC_BITS-1:0], 2'(k));
                end
                ax_reg      <= tx0_mag[11:0];
                ay_reg      <= ty0_mag[11:0];
                negx_reg    <= (tx[0] < 0);
                negy_reg    <= (ty[0] < 0);
                nx_reg      <= nx_mod;
                ny_reg      <= ny_mod;
                remx_reg    <= '0;
                remy_reg    <= '0;
                div_cnt_reg <= '0;
                acc_reg     <= '0;
                xacc_reg    <= '0;
                res_reg     <= '{sample_value: '0, out_of_bounds: cut_miss, saturated: 1'b0};
            end
            ST_REMAP: begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
                if (div_cnt_reg < 4'd12) begin
                    remx_reg <= xs_red;
                    remy_reg <= ys_red;
                    ax_reg   <= {ax_reg[10:0], 1'b0};
                    ay_reg   <= {ay_reg[10:0], 1'b0};
                end else begin
                    cx_reg[div_cnt_reg[1:0]] <= map_x;
                    cy_reg[div_cnt_reg[1:0]] <= map_y;
                    remx_reg <= xr_inc;
                    remy_reg <= yr_inc;
                end
            end
            ST_MAC: acc_reg <= acc_reg + mac_prod;
            ST_COL: begin
                xacc_reg <= xacc_reg + mac_prod;
                acc_reg  <= '0;
            end
            ST_FIN: begin
                if (fin_val > 34'sd32767) begin
                    res_reg.sample_value <= 16'sh7FFF;
                    res_reg.saturated    <= 1'b1;
                end else if (fin_val < -34'sd32768) begin
                    res_reg.sample_value <= -16'sh8000;
                    res_reg.saturated    <= 1'b1;
                end else begin
                    res_reg.sample_value <= 16'(fin_val);
                end
            end
            default: ;
        endcase
    end

    a_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    a_cut_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_of_bounds) |-> (m_data.sample_value == 16'sd0 &&
        !m_data.saturated)) else $error("cut result not zero");
    a_flag_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_of_bounds) |-> (mode_reg == MODE_CUT))
        else $error("out_of_bounds outside cutting mode");
endmodule
